// ===== rtl/core/tillson_t3_moving_average_assert.svh =====
// assertion macros for the checker file of the t3 moving average
`ifndef TILLSON_T3_MOVING_AVERAGE_ASSERT_SVH
`define TILLSON_T3_MOVING_AVERAGE_ASSERT_SVH

// condition in this cycle implies consequence in the next cycle
`define TTMA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ttma next-cycle check failed");

// condition implies consequence in the same cycle
`define TTMA_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ttma same-cycle check failed");

`endif

// ===== rtl/core/ttma_pkg.sv =====
// types, constants and rounding helpers of the t3 moving average
package ttma_pkg;

	localparam int FRAC       = 24;
	localparam int MAX_PERIOD = 1024;
	localparam int STAGES     = 6;
	localparam int PW         = 11;
	localparam int VW         = 17;
	localparam int SW         = 56;
	localparam int KW         = 24;
	localparam int DIV_NW     = FRAC + 2;
	localparam int OUT_SHIFT  = 32 + FRAC;

	localparam logic REG_PERIOD = 1'b0;
	localparam logic REG_VOLUME = 1'b1;

	localparam logic [PW-1:0] PERIOD_RESET = 11'd5;
	localparam logic [VW-1:0] VOLUME_RESET = 17'd45875;
	localparam logic [VW-1:0] VOLUME_ONE   = 17'd65536;

	typedef logic signed [63:0]  w64_t;
	typedef logic signed [127:0] w128_t;

	localparam w64_t INT32_MAXV = 64'sd2147483647;
	localparam w64_t INT32_MINV = -64'sd2147483648;

	// control from the sequencer to one cell
	typedef struct packed {
		logic clear;
		logic load;
	} cell_ctl_t;

	// round to nearest, ties up, drop FRAC fraction bits
	function automatic w64_t rnd_frac(input w128_t p);
		w128_t t;
		t = p + (w128_t'(1) <<< (FRAC - 1));
		return t[FRAC+63:FRAC];
	endfunction

	// round to nearest, ties up, down to q16.16 from the coefficient product
	function automatic w64_t rnd_out(input w128_t p);
		w128_t t;
		t = p + (w128_t'(1) <<< (OUT_SHIFT - 1));
		return t[OUT_SHIFT+63:OUT_SHIFT];
	endfunction

	// sign extend a stage value
	function automatic w64_t sext_stage(input logic [SW-1:0] e);
		return {{(64-SW){e[SW-1]}}, e};
	endfunction

endpackage

// ===== rtl/core/tillson_t3_moving_average.sv =====
// t3 moving average: six chained exponential stages in cells, seeding and output sequencer
// one item at a time; in the first seeding phase each item is summed, the period's last seeds
// an item after that runs the chain cell by cell through the active cells, then may seed the next
// a result sums four serial products of coefficients and stages, then waits out output stalls
// after reset or a config write the factors are rebuilt, no input taken
// reset: period 5, volume factor 45875, all stages and warm-up state cleared
module tillson_t3_moving_average
	import ttma_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	input  logic [31:0]   s_axis_tdata,   // [31:0] sample
	input  logic          s_axis_tuser,   // [0] new_series
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	output logic [31:0]   m_axis_tdata,   // [31:0] smoothed
	output logic          m_axis_tuser,   // [0] overflowed
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic          cfg_index,
	input  logic [VW-1:0] cfg_data
);

	typedef enum logic [3:0] {
		ST_DIVK, ST_DIVK_W, ST_DIVI, ST_DIVI_W, ST_V2, ST_V3, ST_COEF,
		ST_IDLE, ST_DISP, ST_CHAIN, ST_MEAN, ST_OUTGO, ST_OUTM, ST_OUTFIN
	} state_t;

	state_t          state_q;
	logic [PW-1:0]   period_q;
	logic [VW-1:0]   vf_q;
	logic [KW-1:0]   kq_q;
	logic [KW-1:0]   invq_q;
	logic [32:0]     v2_q;
	logic [48:0]     v3_q;
	w64_t            c1_q, c2_q, c3_q, c4_q;
	w64_t            x_q;
	w64_t            seed_sum_q;
	logic [PW-1:0]   cnt_q;
	logic [2:0]      seeding_q;
	logic [1:0]      oidx_q;
	w128_t           acc_q;
	logic            m_valid_q;
	logic [31:0]     m_data_q;
	logic            m_ovf_q;

	logic [PW-1:0]   p_act;
	logic [PW-1:0]   p_plus1;
	logic [VW-1:0]   v_cl;
	logic            cfg_xfer;
	logic            in_xfer;

	logic              div_start;
	logic [DIV_NW-1:0] div_num;
	logic [PW-1:0]     div_den;
	logic              div_done;
	logic [DIV_NW-1:0] div_quo;

	logic            tm_start;
	w64_t            tm_a;
	w64_t            tm_b;
	logic            tm_done;
	w128_t           tm_p;

	logic [SW-1:0]   cell_e     [STAGES];
	logic            cell_done  [STAGES];
	logic            cell_start [STAGES];
	w64_t            cell_src   [STAGES];
	cell_ctl_t       cell_ctl   [STAGES];

	logic [SW-1:0]   stage_sel;
	w64_t            seed_add;
	w64_t            seed_nx;
	logic [PW-1:0]   cnt_nx;
	logic            chain_done;
	logic            mean_start;
	logic            out_start;
	logic            out_phase;
	logic [1:0]      oidx_nx;
	w64_t            coef_sel;
	logic [SW-1:0]   e_sel;
	logic            clear_all;
	logic            mean_load;
	w64_t            mean_val;
	w64_t            c1_nx, c2_nx, c3_nx, c4_nx;
	w64_t            v_s32, v2_s16, v3_s;
	w64_t            r_out;

	// active period and volume factor after clamping
	always_comb begin
		p_act = period_q;
		if (period_q < PW'(2))
			p_act = PW'(2);
		else if (period_q > PW'(MAX_PERIOD))
			p_act = PW'(MAX_PERIOD);
		v_cl = (vf_q > VOLUME_ONE) ? VOLUME_ONE : vf_q;
	end
	assign p_plus1 = p_act + PW'(1);

	// config only while idle, so a rebuild always runs on settled registers
	assign cfg_ready     = (state_q == ST_IDLE);
	assign cfg_xfer      = cfg_valid && cfg_ready;
	assign s_axis_tready = (state_q == ST_IDLE) && !cfg_valid;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;

	// rounded k and reciprocal of the period
	assign div_start = (state_q == ST_DIVK) || (state_q == ST_DIVI);
	assign div_num   = (state_q == ST_DIVK)
	                   ? (DIV_NW'(1) << (FRAC + 1)) + DIV_NW'(p_plus1 >> 1)
	                   : (DIV_NW'(1) << FRAC) + DIV_NW'(p_act >> 1);
	assign div_den   = (state_q == ST_DIVK) ? p_plus1 : p_act;

	ttma_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	// output coefficients from the volume factor
	always_comb begin
		v_s32  = w64_t'({15'b0, v_cl}) <<< 32;
		v2_s16 = w64_t'({31'b0, v2_q}) <<< 16;
		v3_s   = w64_t'({15'b0, v3_q});
		c1_nx  = -v3_s;
		c2_nx  = (v2_s16 <<< 1) + v2_s16 + (v3_s <<< 1) + v3_s;
		c3_nx  = -((v2_s16 <<< 2) + (v2_s16 <<< 1)) - ((v_s32 <<< 1) + v_s32)
		         - ((v3_s <<< 1) + v3_s);
		c4_nx  = (w64_t'(1) <<< 48) + (v_s32 <<< 1) + v_s32 + (v2_s16 <<< 1) + v2_s16
		         + v3_s;
	end

	// chain of cells, the first started by the sequencer and each other one by the one before it
	assign clear_all = in_xfer && s_axis_tuser;
	assign mean_load = (state_q == ST_MEAN) && tm_done;
	assign mean_val  = rnd_frac(tm_p);

	generate
		for (genvar i = 0; i < STAGES; i++) begin : g_cell
			if (i == 0) begin : g_first
				assign cell_src[i]   = x_q;
				assign cell_start[i] = (state_q == ST_DISP) && (seeding_q != 3'd0);
			end else begin : g_rest
				assign cell_src[i]   = sext_stage(cell_e[i-1]);
				assign cell_start[i] = cell_done[i-1] && (3'(i) < seeding_q);
			end
			assign cell_ctl[i].clear = clear_all;
			assign cell_ctl[i].load  = mean_load && (seeding_q == 3'(i));

			ttma_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctl      (cell_ctl[i]),
				.load_val (mean_val),
				.start    (cell_start[i]),
				.src      (cell_src[i]),
				.kq       (kq_q),
				.e        (cell_e[i]),
				.done     (cell_done[i])
			);
		end
	endgenerate

	// seeding sums and selections for the shared multiplier
	always_comb begin
		case (seeding_q)
			3'd1:    stage_sel = cell_e[0];
			3'd2:    stage_sel = cell_e[1];
			3'd3:    stage_sel = cell_e[2];
			3'd4:    stage_sel = cell_e[3];
			3'd5:    stage_sel = cell_e[4];
			default: stage_sel = cell_e[5];
		endcase
		case (seeding_q)
			3'd1:    chain_done = cell_done[0];
			3'd2:    chain_done = cell_done[1];
			3'd3:    chain_done = cell_done[2];
			3'd4:    chain_done = cell_done[3];
			3'd5:    chain_done = cell_done[4];
			default: chain_done = cell_done[5];
		endcase
		seed_add = (state_q == ST_DISP) ? x_q : sext_stage(stage_sel);
		seed_nx  = seed_sum_q + seed_add;
		cnt_nx   = cnt_q + PW'(1);

		mean_start = ((state_q == ST_DISP) && (seeding_q == 3'd0) && (cnt_nx >= p_act)) ||
		             ((state_q == ST_CHAIN) && chain_done && (seeding_q < 3'(STAGES)) &&
		              (cnt_nx >= p_act - PW'(1)));

		out_phase = (state_q == ST_OUTGO) || (state_q == ST_OUTM);
		out_start = (state_q == ST_OUTGO) ||
		            ((state_q == ST_OUTM) && tm_done && (oidx_q != 2'd3));
		oidx_nx   = (state_q == ST_OUTGO) ? 2'd0 : oidx_q + 2'd1;
		case (oidx_nx)
			2'd0: begin
				coef_sel = c1_q;
				e_sel    = cell_e[5];
			end
			2'd1: begin
				coef_sel = c2_q;
				e_sel    = cell_e[4];
			end
			2'd2: begin
				coef_sel = c3_q;
				e_sel    = cell_e[3];
			end
			default: begin
				coef_sel = c4_q;
				e_sel    = cell_e[2];
			end
		endcase

		tm_start = mean_start || out_start;
		tm_a     = out_phase ? coef_sel : seed_nx;
		tm_b     = out_phase ? sext_stage(e_sel) : w64_t'({{(64-KW){1'b0}}, invq_q});
	end

	ttma_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (tm_start),
		.a      (tm_a),
		.b      (tm_b),
		.done   (tm_done),
		.p      (tm_p)
	);

	assign r_out = rnd_out(acc_q);

	// sequencer, configuration registers and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_DIVK;
			period_q   <= PERIOD_RESET;
			vf_q       <= VOLUME_RESET;
			seed_sum_q <= '0;
			cnt_q      <= '0;
			seeding_q  <= '0;
			oidx_q     <= '0;
			m_valid_q  <= 1'b0;
		end else begin
			if (m_valid_q && m_axis_tready)
				m_valid_q <= 1'b0;

			if (cfg_xfer) begin
				case (cfg_index)
					REG_PERIOD: period_q <= cfg_data[PW-1:0];
					REG_VOLUME: vf_q     <= cfg_data;
					default:    vf_q     <= cfg_data;
				endcase
				state_q <= ST_DIVK;
			end else begin
				case (state_q)
					ST_DIVK:   state_q <= ST_DIVK_W;
					ST_DIVK_W: begin
						if (div_done) begin
							kq_q    <= div_quo[KW-1:0];
							state_q <= ST_DIVI;
						end
					end
					ST_DIVI:   state_q <= ST_DIVI_W;
					ST_DIVI_W: begin
						if (div_done) begin
							invq_q  <= div_quo[KW-1:0];
							state_q <= ST_V2;
						end
					end
					ST_V2: begin
						v2_q    <= 33'(v_cl * v_cl);
						state_q <= ST_V3;
					end
					ST_V3: begin
						v3_q    <= 49'(v2_q * v_cl);
						state_q <= ST_COEF;
					end
					ST_COEF: begin
						c1_q    <= c1_nx;
						c2_q    <= c2_nx;
						c3_q    <= c3_nx;
						c4_q    <= c4_nx;
						state_q <= ST_IDLE;
					end
					ST_IDLE: begin
						if (in_xfer) begin
							x_q <= {{(48-FRAC){s_axis_tdata[31]}}, s_axis_tdata,
							        {(FRAC-16){1'b0}}};
							if (s_axis_tuser) begin
								seed_sum_q <= '0;
								cnt_q      <= '0;
								seeding_q  <= '0;
							end
							state_q <= ST_DISP;
						end
					end
					ST_DISP: begin
						if (seeding_q == 3'd0) begin
							seed_sum_q <= seed_nx;
							cnt_q      <= cnt_nx;
							state_q    <= mean_start ? ST_MEAN : ST_IDLE;
						end else begin
							state_q <= ST_CHAIN;
						end
					end
					ST_CHAIN: begin
						if (chain_done) begin
							if (seeding_q < 3'(STAGES)) begin
								seed_sum_q <= seed_nx;
								cnt_q      <= cnt_nx;
								state_q    <= mean_start ? ST_MEAN : ST_IDLE;
							end else begin
								state_q <= ST_OUTGO;
							end
						end
					end
					ST_MEAN: begin
						if (tm_done) begin
							seed_sum_q <= mean_val;
							cnt_q      <= '0;
							seeding_q  <= seeding_q + 3'd1;
							state_q    <= (seeding_q == 3'(STAGES - 1)) ? ST_OUTGO : ST_IDLE;
						end
					end
					ST_OUTGO: begin
						acc_q   <= '0;
						oidx_q  <= '0;
						state_q <= ST_OUTM;
					end
					ST_OUTM: begin
						if (tm_done) begin
							acc_q <= acc_q + tm_p;
							if (oidx_q == 2'd3)
								state_q <= ST_OUTFIN;
							else
								oidx_q <= oidx_q + 2'd1;
						end
					end
					ST_OUTFIN: begin
						// wait until the output register is free
						if (!m_valid_q || m_axis_tready) begin
							m_valid_q <= 1'b1;
							if (r_out > INT32_MAXV) begin
								m_data_q <= INT32_MAXV[31:0];
								m_ovf_q  <= 1'b1;
							end else if (r_out < INT32_MINV) begin
								m_data_q <= INT32_MINV[31:0];
								m_ovf_q  <= 1'b1;
							end else begin
								m_data_q <= r_out[31:0];
								m_ovf_q  <= 1'b0;
							end
							state_q <= ST_IDLE;
						end
					end
					default: state_q <= ST_IDLE;
				endcase
			end
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_ovf_q;

endmodule

// ===== rtl/core/ttma_mul.sv =====
// signed 64 by 64 multiplier, sixteen bits of the second operand per cycle, one product at a time
module ttma_mul
	import ttma_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  w64_t  a,
	input  w64_t  b,
	output logic  done,
	output w128_t p
);

	logic [63:0]  ma_q;
	logic [63:0]  mb_q;
	logic         neg_q;
	logic [127:0] acc_q;
	logic [1:0]   cnt_q;
	logic         busy_q;
	logic         fin_q;
	logic         done_q;
	w128_t        p_q;
	logic [79:0]  pp;
	logic [127:0] acc_nx;

	// one partial product per cycle, accumulator shifts right
	assign pp     = ma_q * mb_q[15:0];
	assign acc_nx = {16'b0, acc_q[127:16]} + {pp, 48'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			fin_q  <= 1'b0;
			if (start && !busy_q) begin
				ma_q   <= a[63] ? 64'(-a) : 64'(a);
				mb_q   <= b[63] ? 64'(-b) : 64'(b);
				neg_q  <= a[63] ^ b[63];
				acc_q  <= '0;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				acc_q <= acc_nx;
				mb_q  <= {16'b0, mb_q[63:16]};
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
			// apply the sign in a registered step of its own
			if (fin_q) begin
				p_q    <= neg_q ? -w128_t'(acc_q) : w128_t'(acc_q);
				done_q <= 1'b1;
			end
		end
	end

	assign done = done_q;
	assign p    = p_q;

endmodule

// ===== rtl/core/ttma_div.sv =====
// restoring divider for the smoothing factor and reciprocal, one bit per cycle
module ttma_div
	import ttma_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIV_NW-1:0] num,
	input  logic [PW-1:0]     den,
	output logic              done,
	output logic [DIV_NW-1:0] quo
);

	localparam int CNTW = $clog2(DIV_NW);

	logic [DIV_NW-1:0] n_q;
	logic [DIV_NW-1:0] q_q;
	logic [PW:0]       rem_q;
	logic [PW-1:0]     den_q;
	logic [CNTW-1:0]   cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [PW:0]       rem_sh;
	logic              ge;

	assign rem_sh = {rem_q[PW-1:0], n_q[DIV_NW-1]};
	assign ge     = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				n_q    <= num;
				den_q  <= den;
				rem_q  <= '0;
				q_q    <= '0;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				// one quotient bit per cycle
				rem_q <= ge ? rem_sh - {1'b0, den_q} : rem_sh;
				q_q   <= {q_q[DIV_NW-2:0], ge};
				n_q   <= {n_q[DIV_NW-2:0], 1'b0};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNTW'(DIV_NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quo  = q_q;

endmodule

// ===== rtl/core/ttma_cell.sv =====
// one exponential stage of the chain: holds its average, updates it on start, clears or loads it on command
module ttma_cell
	import ttma_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  cell_ctl_t     ctl,
	input  w64_t          load_val,
	input  logic          start,
	input  w64_t          src,
	input  logic [KW-1:0] kq,
	output logic [SW-1:0] e,
	output logic          done
);

	logic [SW-1:0] e_q;
	logic          done_q;
	w64_t          diff;
	logic          mul_done;
	w128_t         mul_p;
	w64_t          upd;

	// k times the distance to the source
	assign diff = src - sext_stage(e_q);

	ttma_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.a      (diff),
		.b      ({{(64-KW){1'b0}}, kq}),
		.done   (mul_done),
		.p      (mul_p)
	);

	assign upd = rnd_frac(mul_p);

	// stage value and hand-off pulse to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e_q    <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (ctl.clear) begin
				e_q <= '0;
			end else if (ctl.load) begin
				e_q <= load_val[SW-1:0];
			end else if (mul_done) begin
				e_q    <= e_q + upd[SW-1:0];
				done_q <= 1'b1;
			end
		end
	end

	assign e    = e_q;
	assign done = done_q;

endmodule

// ===== rtl/core/ttma_checker.sv =====
// port-level checks of the t3 moving average, bound to the top level
`include "tillson_t3_moving_average_assert.svh"

module ttma_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic        m_axis_tuser,
	input logic        cfg_valid,
	input logic        cfg_ready
);

	// a stalled result keeps its payload
	`TTMA_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

	// one item at a time: no input transfer right after one
	`TTMA_ASSERT_NEXT(a_one_item, s_axis_tvalid && s_axis_tready, !s_axis_tready)

	// a config write rebuilds the factors before the next input
	`TTMA_ASSERT_NEXT(a_cfg_rebuild, cfg_valid && cfg_ready, !s_axis_tready)

	// config and input never transfer in the same cycle
	`TTMA_ASSERT_SAME(a_cfg_excl, cfg_valid && cfg_ready, !(s_axis_tvalid && s_axis_tready))

endmodule

bind tillson_t3_moving_average ttma_checker u_ttma_checker (.*);
